[hdl/pee_pkg.sv]
// shared types and codes for the postfix expression evaluator
package pee_pkg;

   localparam int unsigned DATA_W = 32;

   typedef enum logic [2:0] {
      OP_PUSH   = 3'd0,
      OP_ADD    = 3'd1,
      OP_SUB    = 3'd2,
      OP_MUL    = 3'd3,
      OP_DIV    = 3'd4,
      OP_EQUALS = 3'd5,
      OP_BAD    = 3'd6,
      OP_END    = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EXPR     = 3'd1,
      ST_DIV0     = 3'd2,
      ST_MANY     = 3'd3,
      ST_OVERFLOW = 3'd4
   } status_type;

   typedef struct packed {
      logic       push;
      logic       clear;
      logic       fetch;
      logic       alu;
      op_type     alu_op;
      logic       div_start;
      logic       div_finish;
      logic       drop_two;
      logic       emit;
      status_type rsp_code;
   } dp_cmd_type;

   typedef struct packed {
      logic depth_zero;
      logic depth_one;
      logic depth_ge2;
      logic full;
      logic b_zero;
      logic div_done;
      logic out_busy;
   } dp_status_type;

endpackage

[hdl/pee_ram.sv]
// generic single write port, single registered read port ram
module pee_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/pee_dp.sv]
// datapath: operand stack, top register, alu, iterative divider, result register
module pee_dp
   import pee_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic [DATA_W-1:0]   push_value,
   output dp_status_type       status,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [DATA_W-1:0]   rsp_answer,
   output logic [2:0]          rsp_status
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned CW = $clog2(DATA_W + 1);

   logic [DW-1:0]     depth_ff, depth_in;
   logic [DATA_W-1:0] tos_ff, tos_in;
   logic [DW-1:0]     depth_m1, depth_m2;
   logic [DATA_W-1:0] a_val, alu_res, prod;

   logic [DATA_W-1:0] rem_ff, quo_ff, dvs_ff;
   logic              neg_ff;
   logic [CW-1:0]     cnt_ff;
   logic [DATA_W:0]   shifted, diff;
   logic [DATA_W-1:0] quotient, mag_a, mag_b;

   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_answer_ff;
   logic [2:0]        rsp_status_ff;

   assign depth_m1 = depth_ff - DW'(1);
   assign depth_m2 = depth_ff - DW'(2);

   pee_ram #(
      .WIDTH (DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (cmd.push && (depth_ff != '0)),
      .wr_addr (depth_m1[AW-1:0]),
      .wr_data (tos_ff),
      .rd_en   (cmd.fetch),
      .rd_addr (depth_m2[AW-1:0]),
      .rd_data (a_val)
   );

   assign prod = a_val * tos_ff;

   always_comb begin
      case (cmd.alu_op)
         OP_ADD:  alu_res = a_val + tos_ff;
         OP_SUB:  alu_res = a_val - tos_ff;
         default: alu_res = prod;
      endcase
   end

   assign mag_a    = a_val[DATA_W-1] ? (DATA_W'(0) - a_val) : a_val;
   assign mag_b    = tos_ff[DATA_W-1] ? (DATA_W'(0) - tos_ff) : tos_ff;
   assign shifted  = {rem_ff, quo_ff[DATA_W-1]};
   assign diff     = shifted - {1'b0, dvs_ff};
   assign quotient = neg_ff ? (DATA_W'(0) - quo_ff) : quo_ff;

   always_comb begin
      depth_in = depth_ff;
      tos_in   = tos_ff;
      if (cmd.clear) begin
         depth_in = '0;
      end else if (cmd.push) begin
         depth_in = depth_ff + DW'(1);
         tos_in   = push_value;
      end else if (cmd.alu) begin
         depth_in = depth_m1;
         tos_in   = alu_res;
      end else if (cmd.div_finish) begin
         depth_in = depth_m1;
         tos_in   = quotient;
      end else if (cmd.drop_two) begin
         depth_in = depth_m2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff     <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         depth_ff <= depth_in;
         if (cmd.div_start) begin
            cnt_ff <= CW'(DATA_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - CW'(1);
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      tos_ff <= tos_in;
      if (cmd.div_start) begin
         rem_ff <= '0;
         quo_ff <= mag_a;
         dvs_ff <= mag_b;
         neg_ff <= a_val[DATA_W-1] ^ tos_ff[DATA_W-1];
      end else if (cnt_ff != '0) begin
         if (!diff[DATA_W]) begin
            rem_ff <= diff[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[DATA_W-1:0];
            quo_ff <= {quo_ff[DATA_W-2:0], 1'b0};
         end
      end
      if (cmd.emit) begin
         rsp_status_ff <= cmd.rsp_code;
         rsp_answer_ff <= (cmd.rsp_code == ST_OK) ? tos_ff : '0;
      end
   end

   assign status.depth_zero = (depth_ff == '0);
   assign status.depth_one  = (depth_ff == DW'(1));
   assign status.depth_ge2  = (depth_ff >= DW'(2));
   assign status.full       = (depth_ff == DW'(STACK_DEPTH));
   assign status.b_zero     = (tos_ff == '0);
   assign status.div_done   = (cnt_ff == '0);
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_answer = rsp_answer_ff;
   assign rsp_status = rsp_status_ff;

endmodule

[hdl/pee_ctrl.sv]
// controller: token decode, error latch and operator sequencing
module pee_ctrl
   import pee_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [2:0]    req_op,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_FETCH,
      S_EXEC,
      S_DIVIDE
   } state_type;

   state_type  state_ff, state_in;
   status_type error_ff, error_in;
   logic       stopped_ff, stopped_in;
   op_type     op_ff, op_in;
   op_type     op_now;
   logic       xfer;

   assign op_now     = op_type'(req_op);
   assign req_tready = (state_ff == S_IDLE) && !(status.out_busy && (op_now == OP_END));
   assign xfer       = req_tvalid && req_tready;

   always_comb begin
      state_in   = state_ff;
      error_in   = error_ff;
      stopped_in = stopped_ff;
      op_in      = op_ff;
      cmd        = '0;
      cmd.alu_op = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (xfer) begin
               if (op_now == OP_END) begin
                  cmd.emit  = 1'b1;
                  cmd.clear = 1'b1;
                  if (error_ff != ST_OK) begin
                     cmd.rsp_code = error_ff;
                  end else if (status.depth_one) begin
                     cmd.rsp_code = ST_OK;
                  end else if (status.depth_ge2) begin
                     cmd.rsp_code = ST_MANY;
                  end else begin
                     cmd.rsp_code = ST_EXPR;
                  end
                  error_in   = ST_OK;
                  stopped_in = 1'b0;
               end else if (!stopped_ff) begin
                  unique case (op_now) inside
                     OP_PUSH: begin
                        if (status.full) begin
                           error_in   = ST_OVERFLOW;
                           stopped_in = 1'b1;
                        end else begin
                           cmd.push = 1'b1;
                        end
                     end
                     OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                        if (status.depth_ge2) begin
                           op_in    = op_now;
                           state_in = S_FETCH;
                        end else begin
                           error_in   = ST_EXPR;
                           stopped_in = 1'b1;
                        end
                     end
                     OP_EQUALS: begin
                        stopped_in = 1'b1;
                     end
                     default: begin
                        error_in   = ST_EXPR;
                        stopped_in = 1'b1;
                     end
                  endcase
               end
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_EXEC;
         end
         S_EXEC: begin
            if (op_ff == OP_DIV) begin
               if (status.b_zero) begin
                  cmd.drop_two = 1'b1;
                  error_in     = ST_DIV0;
                  stopped_in   = 1'b1;
                  state_in     = S_IDLE;
               end else begin
                  cmd.div_start = 1'b1;
                  state_in      = S_DIVIDE;
               end
            end else begin
               cmd.alu  = 1'b1;
               state_in = S_IDLE;
            end
         end
         S_DIVIDE: begin
            if (status.div_done) begin
               cmd.div_finish = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         error_ff   <= ST_OK;
         stopped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         error_ff   <= error_in;
         stopped_ff <= stopped_in;
      end
      op_ff <= op_in;
   end

`ifndef NO_ASSERTIONS
   a_fetch_then_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FETCH) |=> (state_ff == S_EXEC))
      else $error("fetch not followed by execute");

   a_exec_has_operands: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC) |-> status.depth_ge2)
      else $error("operator executing with fewer than two operands");

   a_busy_not_stopped: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !stopped_ff)
      else $error("operator in flight while stopped");

   a_end_emits: assert property (@(posedge clock) disable iff (reset)
      (xfer && (op_now == OP_END)) |=> status.depth_zero && (error_ff == ST_OK))
      else $error("line end did not return to reset state");
`endif

endmodule

[hdl/postfix_expression_evaluator.sv]
// postfix expression evaluator top level
// push, equals, bad token, line end: one token per cycle; line end waits on rsp
// add, subtract, multiply: fetch (stack ram registered read), then execute
// divide: fetch, execute, then the 32-step restoring divider
// line end result is registered onto rsp in the cycle after its transfer
// synchronous active-high reset clears depth, error latch and result valid
module postfix_expression_evaluator
   import pee_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // value[31:0]
   input  logic [2:0]  req_tuser,   // op[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // answer[31:0]
   output logic [2:0]  rsp_tuser    // status[2:0]
);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [DATA_W-1:0] rsp_answer;
   logic [2:0]        rsp_status;

   pee_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   pee_dp #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .push_value (req_tdata),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_answer (rsp_answer),
      .rsp_status (rsp_status)
   );

   assign rsp_tdata = rsp_answer;
   assign rsp_tuser = rsp_status;

endmodule

[tb/tb.sv]
// self-checking testbench for the postfix expression evaluator
module tb;
   import pee_pkg::*;

   localparam int DEPTH = 16;
   localparam int ITEM_TARGET = 1850;

   typedef struct {
      status_type status;
      bit [31:0]  answer;
   } line_result_type;

   class rpn_scoreboard;
      bit [31:0]       operands [DEPTH];
      int unsigned     depth;
      status_type      err_code;
      bit              halted;
      line_result_type expected_lines [$];
      int              mismatches;

      function new();
         clear_line();
         mismatches = 0;
      endfunction

      function void clear_line();
         foreach (operands[i]) operands[i] = '0;
         depth = 0;
         err_code = ST_OK;
         halted = 1'b0;
      endfunction

      function void latch_error(status_type code);
         err_code = code;
         halted = 1'b1;
      endfunction

      // signed divide, truncating toward zero, most negative by minus one wraps
      function bit [31:0] trunc_quotient(bit [31:0] a, bit [31:0] b);
         bit        neg;
         bit [31:0] mag_a;
         bit [31:0] mag_b;
         bit [31:0] q;
         neg = a[31] ^ b[31];
         mag_a = a[31] ? (32'd0 - a) : a;
         mag_b = b[31] ? (32'd0 - b) : b;
         q = mag_a / mag_b;
         return neg ? (32'd0 - q) : q;
      endfunction

      function int pending();
         return expected_lines.size();
      endfunction

      function void note_token(op_type op, bit [31:0] value);
         line_result_type res;
         bit [31:0]       a;
         bit [31:0]       b;
         bit [31:0]       r;
         if (op == OP_END) begin
            res.answer = '0;
            if (err_code != ST_OK) begin
               res.status = err_code;
            end else if (depth == 1) begin
               res.status = ST_OK;
               res.answer = operands[0];
            end else if (depth > 1) begin
               res.status = ST_MANY;
            end else begin
               res.status = ST_EXPR;
            end
            expected_lines.push_back(res);
            clear_line();
            return;
         end
         if (halted) return;
         case (op) inside
            OP_PUSH: begin
               if (depth >= DEPTH) begin
                  latch_error(ST_OVERFLOW);
               end else begin
                  operands[depth] = value;
                  depth++;
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
               if (depth < 2) begin
                  latch_error(ST_EXPR);
                  return;
               end
               b = operands[depth - 1];
               a = operands[depth - 2];
               case (op)
                  OP_ADD: r = a + b;
                  OP_SUB: r = a - b;
                  OP_MUL: r = a * b;
                  default: begin
                     if (b == 0) begin
                        depth -= 2;
                        latch_error(ST_DIV0);
                        return;
                     end
                     r = trunc_quotient(a, b);
                  end
               endcase
               depth--;
               operands[depth - 1] = r;
            end
            OP_EQUALS: halted = 1'b1;
            default: latch_error(ST_EXPR);
         endcase
      endfunction

      function void check_result(logic [2:0] got_status, logic [31:0] got_answer);
         line_result_type exp_res;
         if (expected_lines.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with nothing expected: status %0d answer %h",
                        got_status, got_answer);
            return;
         end
         exp_res = expected_lines.pop_front();
         if (got_status !== exp_res.status || got_answer !== exp_res.answer) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: status exp %0d got %0d, answer exp %h got %h",
                        exp_res.status, got_status, exp_res.answer, got_answer);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // value[31:0]
   logic [2:0]  req_tuser = '0;   // op[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;        // answer[31:0]
   logic [2:0]  rsp_tuser;        // status[2:0]

   rpn_scoreboard sb = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int items_sent = 0;

   postfix_expression_evaluator #(.STACK_DEPTH(DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #6 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_token(op_type'(req_tuser), req_tdata);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata);
      end
   end

   // entered and left at a falling edge
   task automatic send_token(op_type op, bit [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= value;
      req_tuser <= op;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic bit [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         4: return 32'd1;
         5, 6: return $urandom_range(200) - 100;
         default: return $urandom;
      endcase
   endfunction

   function automatic op_type pick_operator();
      case ($urandom_range(3))
         0: return OP_ADD;
         1: return OP_SUB;
         2: return OP_MUL;
         default: return OP_DIV;
      endcase
   endfunction

   // well-formed expression with n_push operands; unreduced lines leave extra values
   task automatic send_expression(int n_push, bit reduce);
      int d;
      int pushed;
      d = 0;
      pushed = 0;
      while (pushed < n_push || (reduce && d > 1)) begin
         if (pushed < n_push && (d < 2 || $urandom_range(1) == 0)) begin
            send_token(OP_PUSH, pick_value());
            pushed++;
            d++;
         end else begin
            send_token(pick_operator(), $urandom);
            d--;
         end
      end
      if ($urandom_range(3) == 0) begin
         send_token(OP_EQUALS, $urandom);
         repeat ($urandom_range(3)) send_token(op_type'($urandom_range(6)), $urandom);
      end
      send_token(OP_END, $urandom);
   endtask

   task automatic send_noise_line();
      repeat ($urandom_range(1, 8)) send_token(op_type'($urandom_range(6)), $urandom);
      send_token(OP_END, $urandom);
   endtask

   task automatic send_overflow_line();
      repeat (DEPTH + $urandom_range(3)) send_token(OP_PUSH, pick_value());
      if ($urandom_range(1)) send_token(pick_operator(), $urandom);
      send_token(OP_END, $urandom);
   endtask

   initial begin
      int line_no;
      int kind;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // most negative by minus one
      send_token(OP_PUSH, 32'h8000_0000);
      send_token(OP_PUSH, 32'hFFFF_FFFF);
      send_token(OP_DIV, 32'd0);
      send_token(OP_END, 32'd0);
      // divide by zero, later operator ignored
      send_token(OP_PUSH, 32'd7);
      send_token(OP_PUSH, 32'd0);
      send_token(OP_DIV, 32'd0);
      send_token(OP_ADD, 32'd0);
      send_token(OP_END, 32'd0);
      // operator with too few operands
      send_token(OP_ADD, 32'd0);
      send_token(OP_END, 32'd0);
      // empty line
      send_token(OP_END, 32'd0);
      // too many operands
      send_token(OP_PUSH, 32'd5);
      send_token(OP_PUSH, 32'd3);
      send_token(OP_END, 32'd0);
      // equals stops, invalid token after it ignored
      send_token(OP_PUSH, 32'd3);
      send_token(OP_EQUALS, 32'd0);
      send_token(OP_BAD, 32'd0);
      send_token(OP_END, 32'd0);
      // invalid token
      send_token(OP_BAD, 32'hFFFF_FFFF);
      send_token(OP_END, 32'hFFFF_FFFF);
      // wrapping subtract and multiply
      send_token(OP_PUSH, 32'h7FFF_FFFF);
      send_token(OP_PUSH, 32'hFFFF_FFF9);
      send_token(OP_SUB, 32'd0);
      send_token(OP_PUSH, 32'd2);
      send_token(OP_MUL, 32'd0);
      send_token(OP_END, 32'd0);

      drain_results();

      line_no = 0;
      while (items_sent < ITEM_TARGET) begin
         case ((line_no / 8) % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 19; recv_stall_pct = 19; end
         endcase
         kind = $urandom_range(99);
         if (kind < 70) send_expression($urandom_range(1, 12), 1'b1);
         else if (kind < 80) send_expression($urandom_range(2, 10), 1'b0);
         else if (kind < 88) send_noise_line();
         else if (kind < 95) send_overflow_line();
         else send_token(OP_END, $urandom);
         line_no++;
      end

      drain_results();
      repeat (40) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

[files.f]
hdl/pee_pkg.sv
hdl/pee_ram.sv
hdl/pee_dp.sv
hdl/pee_ctrl.sv
hdl/postfix_expression_evaluator.sv
tb/tb.sv
